>>> rtl/daf_pkg.sv
// Shared types, constants and helper functions for the decimal ASCII formatter.
// No dependencies; used by daf_ctrl, daf_datapath and decimal_ascii_formatter.
package daf_pkg;

    localparam int MAX_FRACTION_DIGITS_DEF = 4;
    localparam int INT_DIGITS_MAX          = 5;

    localparam int WHOLE_W = 16;
    localparam int FRAC_W  = 16;
    localparam int COUNT_W = 3;
    localparam int CHAR_W  = 8;
    localparam int REM_W   = 17;   // holds 9 * 10^4 and any 16-bit value
    localparam int POS_W   = 3;    // decimal position 0..4

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_DOT  = 8'h2E;

    typedef struct packed {
        logic               command;
        logic [WHOLE_W-1:0] whole_value;
        logic [FRAC_W-1:0]  fraction_value;
        logic [COUNT_W-1:0] digit_count;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_WHOLE,
        ST_DOT,
        ST_FRAC
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic whole_step;
        logic dot_step;
        logic frac_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic pos_zero;
        logic frac_on;
    } dp_status_t;

    function automatic logic [REM_W-1:0] pow10(input logic [POS_W-1:0] p);
        logic [REM_W-1:0] r;
        unique case (p)
            3'd0:    r = 17'd1;
            3'd1:    r = 17'd10;
            3'd2:    r = 17'd100;
            3'd3:    r = 17'd1000;
            3'd4:    r = 17'd10000;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // d * 10^p for a constant digit d
    function automatic logic [REM_W-1:0] digit_weight(input logic [POS_W-1:0] p,
                                                       input int d);
        logic [REM_W-1:0] r;
        unique case (p)
            3'd0:    r = REM_W'(d);
            3'd1:    r = REM_W'(d * 10);
            3'd2:    r = REM_W'(d * 100);
            3'd3:    r = REM_W'(d * 1000);
            3'd4:    r = REM_W'(d * 10000);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/daf_ctrl.sv
// Sequencer for the formatter: walks load, scale, whole digits, dot, fraction digits.
// Depends on daf_pkg; drives daf_datapath through ctrl_cmd_t.
module daf_ctrl
    import daf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_WHOLE;
            end
            ST_WHOLE:
            begin
                if (status.slot_free)
                begin
                    cmd.whole_step = 1'b1;
                    if (status.pos_zero)
                    begin
                        state_next = status.frac_on ? ST_DOT : ST_IDLE;
                    end
                end
            end
            ST_DOT:
            begin
                if (status.slot_free)
                begin
                    cmd.dot_step = 1'b1;
                    state_next   = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (status.slot_free)
                begin
                    cmd.frac_step = 1'b1;
                    if (status.pos_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/daf_datapath.sv
// Operand registers, fraction scaler, digit unit (one position per unstalled cycle) and output beat register.
// Depends on daf_pkg; commanded by daf_ctrl.
module daf_datapath
    import daf_pkg::*;
#(
    parameter int MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   in_item,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item
);

    localparam int SCALED_W = $clog2(10 ** MAX_FRACTION_DIGITS);
    localparam int PROD_W   = FRAC_W + REM_W;

    logic               cmd_mode_reg;
    logic [COUNT_W-1:0] min_reg;
    logic [COUNT_W-1:0] k_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               seen_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;
    logic [WHOLE_W-1:0] in_item_whole_hold;
    logic [WHOLE_W-1:0] whole_reg;

    logic [PROD_W-1:0]  prod;
    logic [3:0]         digit;
    logic [REM_W-1:0]   sub;
    logic               lead_skip;
    logic               frac_on;
    logic               emit;
    logic [COUNT_W-1:0] k_in;
    logic [COUNT_W-1:0] min_in;

    assign frac_on = cmd_mode_reg && (k_reg != '0);
    assign prod    = PROD_W'(frac_reg) * PROD_W'(pow10(POS_W'(k_reg)));

    assign k_in  = (in_item.digit_count > COUNT_W'(MAX_FRACTION_DIGITS))
                   ? COUNT_W'(MAX_FRACTION_DIGITS) : in_item.digit_count;
    assign min_in = in_item.command ? '0 :
                    ((in_item.digit_count > COUNT_W'(INT_DIGITS_MAX))
                     ? COUNT_W'(INT_DIGITS_MAX) : in_item.digit_count);

    // largest d with d * 10^pos <= rem
    always_comb
    begin
        digit = '0;
        sub   = '0;
        for (int d = 1; d <= 9; d++)
        begin
            if (rem_reg >= digit_weight(pos_reg, d))
            begin
                digit = 4'(d);
                sub   = digit_weight(pos_reg, d);
            end
        end
    end

    assign lead_skip = (digit == '0) && !seen_reg && (COUNT_W'(pos_reg) >= min_reg)
                       && (pos_reg != '0);
    assign emit = cmd.dot_step || cmd.frac_step || (cmd.whole_step && !lead_skip);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_mode_reg <= in_item.command;
            min_reg      <= min_in;
            k_reg        <= k_in;
            frac_reg     <= in_item.fraction_value;
        end
        if (cmd.prep)
        begin
            scaled_reg <= prod[FRAC_W +: SCALED_W];
            rem_reg    <= REM_W'(in_item_whole_hold);
            pos_reg    <= POS_W'(INT_DIGITS_MAX - 1);
        end
        if (cmd.whole_step || cmd.frac_step)
        begin
            rem_reg <= rem_reg - sub;
            pos_reg <= pos_reg - 1'b1;
        end
        if (cmd.dot_step)
        begin
            rem_reg <= REM_W'(scaled_reg);
            pos_reg <= POS_W'(k_reg - 1'b1);
        end
        if (emit)
        begin
            if (cmd.dot_step)
            begin
                out_reg.char_code <= ASCII_DOT;
                out_reg.last      <= 1'b0;
            end
            else
            begin
                out_reg.char_code <= ASCII_ZERO + CHAR_W'(digit);
                out_reg.last      <= (pos_reg == '0) && (cmd.frac_step || !frac_on);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            whole_reg <= in_item.whole_value;
        end
    end
    assign in_item_whole_hold = whole_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.prep)
            begin
                seen_reg <= 1'b0;
            end
            else if (cmd.whole_step && !lead_skip)
            begin
                seen_reg <= 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.slot_free = !out_valid_reg || out_ready;
    assign status.pos_zero  = (pos_reg == '0);
    assign status.frac_on   = frac_on;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

>>> rtl/decimal_ascii_formatter.sv
// Top level of the decimal ASCII formatter: controller plus datapath.
// Depends on daf_pkg, daf_ctrl and daf_datapath.
//
// Takes one number per input beat (integer mode, or unsigned 16.16 fixed-point mode) and sends
// its decimal ASCII characters, most significant first, one per output beat, with last set on
// the final character. A number is taken in while the block is idle; the prep state then computes
// the scaled fraction with a single multiply, and the digit unit steps one decimal position per
// cycle unless the output stalls: five whole positions (leading zeros outside the integer-mode
// minimum digit count are skipped without a beat), then, in fixed-point mode with a nonzero
// digit count, the dot and the fraction digits. A stalled output beat holds the sequence back.
// The last character sits in an output register, so a new number can be accepted before it is
// taken.
module decimal_ascii_formatter
    import daf_pkg::*;
#(
    parameter int MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    daf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    daf_datapath #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

>>> sim/decimal_ascii_formatter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for decimal_ascii_formatter: directed table, then random numbers.
// Depends on daf_pkg and the formatter RTL; expected characters come from the table text or a local model.
module decimal_ascii_formatter_tb;
    import daf_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 450;
    localparam int CALM_FIRST     = 200;
    localparam int CALM_LAST      = 280;
    localparam int IDLE_PERCENT   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 30;
    localparam int REPORT_MAX     = 10;
    localparam int DIRECTED_ROWS  = 22;

    localparam logic CMD_INTEGER = 1'b0;
    localparam logic CMD_FIXED   = 1'b1;

    typedef struct {
        logic               command;
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        logic [COUNT_W-1:0] count;
        string              text;    // empty: take the expected string from the model
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    logic      calm;
    out_item_t want;
    out_item_t expected_chars[$];
    stim_row_t directed_rows[DIRECTED_ROWS];
    int        mismatches;
    int        numbers_sent;
    int        chars_checked;
    int        idle_cycles;

    decimal_ascii_formatter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void note_mismatch(string msg);
        if (mismatches < REPORT_MAX)
            $display("mismatch: %s", msg);
        mismatches++;
    endfunction

    function automatic string decimal_text(longint unsigned value, int unsigned min_digits);
        string s;
        s = $sformatf("%0d", value);
        while (s.len() < min_digits)
            s = {"0", s};
        return s;
    endfunction

    function automatic void queue_text(string s);
        out_item_t c;
        for (int i = 0; i < s.len(); i++) begin
            c.char_code = s[i];
            c.last      = (i == s.len() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    // Expected string of one number.
    function automatic string format_number(in_item_t it);
        int unsigned     places;
        longint unsigned scale;
        longint unsigned scaled;
        string           s;
        places = it.digit_count;
        if (it.command == CMD_INTEGER) begin
            if (places > INT_DIGITS_MAX)
                places = INT_DIGITS_MAX;
            s = decimal_text(it.whole_value, places);
        end else begin
            s = decimal_text(it.whole_value, 0);
            if (places > MAX_FRACTION_DIGITS_DEF)
                places = MAX_FRACTION_DIGITS_DEF;
            if (places != 0) begin
                scale = 1;
                for (int i = 0; i < places; i++)
                    scale = scale * 10;
                // truncation, no rounding
                scaled = (longint'(it.fraction_value) * scale) >> FRAC_W;
                s = {s, ".", decimal_text(scaled, places)};
            end
        end
        return s;
    endfunction

    function automatic in_item_t random_number();
        in_item_t it;
        it.command = 1'($urandom_range(1));
        case ($urandom_range(9))
            0:       it.whole_value = '0;
            1, 2:    it.whole_value = 16'($urandom_range(9));
            3:       it.whole_value = 16'($urandom_range(99));
            4:       it.whole_value = 16'($urandom_range(999));
            5:       it.whole_value = 16'($urandom_range(9999));
            default: it.whole_value = 16'($urandom);
        endcase
        case ($urandom_range(7))
            0:       it.fraction_value = '0;
            1:       it.fraction_value = '1;
            default: it.fraction_value = 16'($urandom);
        endcase
        it.digit_count = 3'($urandom_range(7));
        return it;
    endfunction

    // Offer one number and hold it until taken; expectations are queued on acceptance.
    task automatic send_number(in_item_t it, string text);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        queue_text(text.len() != 0 ? text : format_number(it));
        numbers_sent++;
    endtask

    // Output side: random back-pressure and the character check.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_chars.size() == 0) begin
                note_mismatch($sformatf("unexpected beat char=%h last=%b",
                                        out_item.char_code, out_item.last));
            end else begin
                want = expected_chars.pop_front();
                if (out_item.char_code !== want.char_code || out_item.last !== want.last)
                    note_mismatch($sformatf("char exp=%h got=%h last exp=%b got=%b",
                                            want.char_code, out_item.char_code,
                                            want.last, out_item.last));
            end
            chars_checked++;
        end
        out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        stim_row_t row;
        in_item_t  it;

        directed_rows = '{
            '{CMD_INTEGER, 16'd0,     16'd0,     3'd0, "0"},
            '{CMD_INTEGER, 16'd0,     16'hFFFF,  3'd0, "0"},
            '{CMD_INTEGER, 16'd0,     16'd0,     3'd5, "00000"},
            '{CMD_INTEGER, 16'd65535, 16'd0,     3'd0, "65535"},
            '{CMD_INTEGER, 16'd65535, 16'd0,     3'd5, "65535"},
            '{CMD_INTEGER, 16'd7,     16'd0,     3'd7, "00007"},
            '{CMD_INTEGER, 16'd42,    16'd0,     3'd6, "00042"},
            '{CMD_INTEGER, 16'd9,     16'd0,     3'd1, "9"},
            '{CMD_INTEGER, 16'd123,   16'd0,     3'd2, ""},
            '{CMD_INTEGER, 16'd10000, 16'd0,     3'd3, ""},
            '{CMD_FIXED,   16'd0,     16'd0,     3'd0, "0"},
            '{CMD_FIXED,   16'd3,     16'hFFFF,  3'd0, "3"},
            '{CMD_FIXED,   16'd0,     16'd0,     3'd4, "0.0000"},
            '{CMD_FIXED,   16'd65535, 16'hFFFF,  3'd4, "65535.9999"},
            '{CMD_FIXED,   16'd65535, 16'hFFFF,  3'd7, "65535.9999"},
            '{CMD_FIXED,   16'd0,     16'hFFFF,  3'd5, "0.9999"},
            '{CMD_FIXED,   16'd1,     16'd32768, 3'd1, "1.5"},
            '{CMD_FIXED,   16'd5,     16'd16384, 3'd2, "5.25"},
            '{CMD_FIXED,   16'd12,    16'd1,     3'd4, "12.0000"},
            '{CMD_FIXED,   16'd100,   16'd6554,  3'd1, ""},
            '{CMD_FIXED,   16'd9,     16'hFFFF,  3'd3, ""},
            '{CMD_FIXED,   16'd40000, 16'hAAAA,  3'd6, ""}
        };

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        out_ready <= 1'b0;
        calm      <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            it.command        = row.command;
            it.whole_value    = row.whole;
            it.fraction_value = row.frac;
            it.digit_count    = row.count;
            send_number(it, row.text);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // one long stretch with both sides always willing
            if (n == CALM_FIRST)
                calm <= 1'b1;
            else if (n == CALM_LAST)
                calm <= 1'b0;
            send_number(random_number(), "");
        end
        in_valid <= 1'b0;

        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d numbers formatted (%0d from the directed table), %0d characters checked",
                 numbers_sent, DIRECTED_ROWS, chars_checked);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
